FILE: rtl/core/gbs_pkg.sv
// Shared types and constants for the greedy box suppressor.
package gbs_pkg;

  localparam int unsigned MAX_KEPT  = 64;
  localparam int unsigned MAX_BOXES = 1024;

  localparam int unsigned ADDR_W = $clog2(MAX_KEPT);
  localparam int unsigned CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int unsigned NUM_W  = $clog2(MAX_BOXES);
  localparam int unsigned THR_W  = 9;

  localparam logic [THR_W-1:0] THR_RESET = 9'd102;

  typedef struct packed {
    logic               frame_start;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic        [14:0] box_width;
    logic        [14:0] box_height;
  } box_in_t;

  typedef struct packed {
    logic [9:0] box_number;
    logic       keep;
    logic [6:0] kept_slot;
    logic       list_full;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic pipe_empty;
  } dp_status_t;

endpackage

FILE: rtl/core/gbs_ctrl.sv
// Sequencer: load, scan of the kept list, pipeline drain, finish.
module gbs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  output gbs_pkg::dp_cmd_t    cmd_o,
  input  gbs_pkg::dp_status_t status_i
);
  import gbs_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_end) begin
          state_d = ST_DRAIN;
        end else begin
          cmd_o.issue = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> status_i.pipe_empty)
    else $error("finish while compares still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy)
    else $error("not busy after a transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.issue, cmd_o.finish}))
    else $error("overlapping datapath commands");

endmodule

FILE: rtl/core/gbs_dp.sv
// Datapath: kept-box memory, overlap compare pipeline, counters and result.
module gbs_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  gbs_pkg::box_in_t           box_i,
  input  logic                       cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]  cfg_wdata_i,
  input  gbs_pkg::dp_cmd_t           cmd_i,
  output gbs_pkg::dp_status_t        status_o,
  output gbs_pkg::result_t           result_o,
  output logic                       result_valid_o
);
  import gbs_pkg::*;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [16:0] right;
    logic signed [16:0] bottom;
    logic        [29:0] area;
  } entry_t;

  logic [THR_W-1:0] thr_q;
  logic [CNT_W-1:0] count_q;
  logic [NUM_W-1:0] number_q;
  logic [CNT_W-1:0] idx_q;
  entry_t           cur_q;
  entry_t           mem [MAX_KEPT];
  entry_t           rd_q;
  logic             v0_q, v1_q, v2_q, v3_q;
  logic [14:0]      ix_q, iy_q;
  logic [29:0]      karea1_q, karea2_q;
  logic [29:0]      inter_q, inter3_q;
  logic [30:0]      uni_q;
  logic             sup_q;
  result_t          result_q;
  logic             valid_q;

  // stage A: overlap lengths
  logic signed [15:0] lo_x, lo_y;
  logic signed [16:0] hi_x, hi_y;
  logic signed [17:0] dx, dy;
  logic [39:0]        lhs, rhs;
  logic               keep, full;

  always_comb begin
    lo_x = (cur_q.left  > rd_q.left)  ? cur_q.left  : rd_q.left;
    lo_y = (cur_q.top   > rd_q.top)   ? cur_q.top   : rd_q.top;
    hi_x = (cur_q.right  < rd_q.right)  ? cur_q.right  : rd_q.right;
    hi_y = (cur_q.bottom < rd_q.bottom) ? cur_q.bottom : rd_q.bottom;
    dx   = {hi_x[16], hi_x} - {{2{lo_x[15]}}, lo_x};
    dy   = {hi_y[16], hi_y} - {{2{lo_y[15]}}, lo_y};
  end

  // stage D: inter * 256 > threshold * union
  assign lhs  = {2'b00, inter3_q, 8'b0};
  assign rhs  = 40'(thr_q) * 40'(uni_q);
  assign keep = ~sup_q;
  assign full = keep && (count_q >= CNT_W'(MAX_KEPT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RESET;
      count_q  <= '0;
      number_q <= '0;
      idx_q    <= '0;
      v0_q     <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      sup_q    <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      v0_q    <= cmd_i.issue;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_q <= cmd_i.finish;
      if (cmd_i.load) begin
        idx_q <= '0;
        sup_q <= 1'b0;
        if (box_i.frame_start) begin
          count_q  <= '0;
          number_q <= '0;
        end
      end
      if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
      if (v3_q && (lhs > rhs)) begin
        sup_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        if (keep && !full) begin
          count_q <= count_q + 1'b1;
        end
        number_q <= (number_q == NUM_W'(MAX_BOXES - 1)) ? '0 : number_q + 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_q.left   <= box_i.box_x;
      cur_q.top    <= box_i.box_y;
      cur_q.right  <= {box_i.box_x[15], box_i.box_x} + {2'b00, box_i.box_width};
      cur_q.bottom <= {box_i.box_y[15], box_i.box_y} + {2'b00, box_i.box_height};
      cur_q.area   <= 30'(box_i.box_width) * 30'(box_i.box_height);
    end
    ix_q     <= (dx > 18'sd0) ? dx[14:0] : 15'd0;
    iy_q     <= (dy > 18'sd0) ? dy[14:0] : 15'd0;
    karea1_q <= rd_q.area;
    inter_q  <= 30'(ix_q) * 30'(iy_q);
    karea2_q <= karea1_q;
    inter3_q <= inter_q;
    uni_q    <= 31'(cur_q.area) + 31'(karea2_q) - 31'(inter_q);
    if (cmd_i.finish) begin
      result_q.box_number <= 10'(number_q);
      result_q.keep       <= keep;
      result_q.kept_slot  <= 7'(count_q);
      result_q.list_full  <= full;
    end
  end

  // kept-box store
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && keep && !full) begin
      mem[count_q[ADDR_W-1:0]] <= cur_q;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[idx_q[ADDR_W-1:0]];
    end
  end

  assign status_o.scan_end   = (idx_q == count_q);
  assign status_o.pipe_empty = ~(v0_q | v1_q | v2_q | v3_q);
  assign result_o            = result_q;
  assign result_valid_o      = valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEPT))
    else $error("kept count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (idx_q < count_q))
    else $error("read beyond the kept list");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.list_full |-> result_o.keep)
    else $error("full flag on a suppressed box");

endmodule

FILE: rtl/core/greedy_box_suppressor_unit.sv
// Top level of the greedy box suppressor: controller plus datapath.
//
//   channel   | handshake            | payload
//   ----------+----------------------+---------------------------
//   box in    | start / busy         | box_i (box_in_t)
//   result    | result_valid_o       | result_o (result_t)
//   config    | cfg_we_i             | cfg_wdata_i (threshold)
//
// For a box with n kept boxes before it, the kept-list memory is read one entry
// per cycle into a four-stage compare pipe.
// The result strobe sits in the first cycle with busy low.
// Reset clears counters and the threshold to 102; the kept list needs no sweep.
// Results cannot be held off by the receiver.
module greedy_box_suppressor_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  gbs_pkg::box_in_t           box_i,
  output gbs_pkg::result_t           result_o,
  output logic                       result_valid_o,
  input  logic                       cfg_we_i,
  input  logic [gbs_pkg::THR_W-1:0]  cfg_wdata_i
);
  import gbs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  gbs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_o    (cmd),
    .status_i (status)
  );

  gbs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .box_i          (box_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule
